// ----- rtl/fla_pkg.sv -----
// Shared constants and types of the queued lock arbiter.
package fla_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int HCNT_W = $clog2(QUEUE_DEPTH + 3);
	localparam int LIM_W = (HCNT_W > 5) ? HCNT_W : 5;

	localparam int CLIENT_W = 32;
	localparam int RID_W = 32;
	localparam int DUR_W = 16;
	localparam int OP_W = 3;
	localparam int ST_W = 3;
	localparam int MAXL_W = 5;

	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 56;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [PADDR_W-1:0] REG_MAX_LOCKS_ADDR = 3'd0;
	localparam logic [MAXL_W-1:0] MAX_LOCKS_RESET = 5'd4;

	typedef enum logic [OP_W-1:0] {
		OP_REQUEST    = 3'd0,
		OP_GRANT      = 3'd1,
		OP_REMOVE     = 3'd2,
		OP_REMOVE_ALL = 3'd3,
		OP_UNLOCK     = 3'd4,
		OP_CHECK      = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK           = 3'd0,
		ST_PENDING      = 3'd1,
		ST_CARD_REMOVED = 3'd2,
		ST_LIMIT        = 3'd3,
		ST_QUEUE_FULL   = 3'd4,
		ST_NOT_FOUND    = 3'd5,
		ST_NOT_OWNER    = 3'd6,
		ST_ACTIVE_LOCK  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		Q_HOLD,
		Q_CMP,
		Q_APPEND,
		Q_DROP
	} qcmd_t;

	typedef struct packed {
		logic [CLIENT_W-1:0] client;
		logic [RID_W-1:0]    rid;
		logic [DUR_W-1:0]    dur;
	} entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              any_hit;
		logic [HCNT_W-1:0] hit_cnt;
		logic              head_hit;
		logic [RID_W-1:0]  head_rid;
		logic [DUR_W-1:0]  head_dur;
	} qstat_t;

endpackage

// ----- rtl/fla_cell.sv -----
// One queue slot: holds an entry, compares its client, shifts toward the head.
module fla_cell import fla_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  qcmd_t               cmd,
	input  logic                occ,
	input  logic                load_en,
	input  logic [CLIENT_W-1:0] key,
	input  entry_t              load,
	input  entry_t              nxt,
	input  logic                prefix_in,
	output entry_t              ent,
	output logic                hit,
	output logic                prefix_out
);

	entry_t ent_q;
	logic   hit_q;

	// prefix_in: an earlier slot matched, so this slot is past the removed entry
	assign prefix_out = prefix_in | hit_q;
	assign ent = ent_q;
	assign hit = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd == Q_CMP) begin
			hit_q <= occ && (ent_q.client == key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == Q_APPEND && load_en) begin
			ent_q <= load;
		end else if (cmd == Q_DROP && prefix_out) begin
			ent_q <= nxt;
		end
	end

endmodule

// ----- rtl/fla_queue.sv -----
// Row of queue slots with the fill count, match count and head view.
module fla_queue import fla_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  qcmd_t               cmd,
	input  logic [CLIENT_W-1:0] key,
	input  entry_t              load,
	output qstat_t              stat
);

	logic [QCNT_W-1:0]      count_q;
	entry_t                 ents   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] hits;
	logic [QUEUE_DEPTH:0]   prefix;

	assign prefix[0] = 1'b0;

	for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
		localparam logic [QCNT_W-1:0] IDX = QCNT_W'(j);
		entry_t nxt;
		if (j == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = ents[j];
		end else begin : g_mid
			assign nxt = ents[j+1];
		end
		fla_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.occ        (IDX < count_q),
			.load_en    (IDX == count_q),
			.key        (key),
			.load       (load),
			.nxt        (nxt),
			.prefix_in  (prefix[j]),
			.ent        (ents[j]),
			.hit        (hits[j]),
			.prefix_out (prefix[j+1])
		);
	end

	always_comb begin
		logic [HCNT_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			acc = acc + HCNT_W'(hits[k]);
		end
		stat.hit_cnt = acc;
	end

	assign stat.count    = count_q;
	assign stat.any_hit  = prefix[QUEUE_DEPTH];
	assign stat.head_hit = hits[0];
	assign stat.head_rid = ents[0].rid;
	assign stat.head_dur = ents[0].dur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd == Q_APPEND) begin
			count_q <= count_q + 1'b1;
		end else if (cmd == Q_DROP && prefix[QUEUE_DEPTH]) begin
			count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/fifo_lock_arbiter_top.sv -----
// Queued lock arbiter top level: stream ports, register port, sequencer.
//
// Queued mutex for one shared resource. Each request on the input stream
// gives exactly one result. An item passes accept, compare across all queue
// slots, execute and the output register in that order; a remove-all goes
// back from execute to compare while an entry of that client stays queued,
// since the slot row drops one matching entry per compare/shift pass. One
// item is in work at a time; a new one is taken as soon as the result sits
// in the output register. A result that waits on m_tready holds the item
// after it in the output stage. The user must write max_locks over the APB
// port at address 0 only while the block is idle; the block does not check.
module fifo_lock_arbiter_top import fla_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// opcode[2:0], client_id[34:3], lock_duration[50:35], card_present[51]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// status[2:0], request_id[34:3], granted_duration[50:35],
	// has_requests[51], idle[52]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [MAXL_W-1:0]   max_locks_q;
	logic [OP_W-1:0]     op_q;
	logic [CLIENT_W-1:0] client_q;
	logic [DUR_W-1:0]    dur_q;
	logic                card_q;
	status_t             status_q;
	logic [RID_W-1:0]    rid_q;
	logic [DUR_W-1:0]    gdur_q;
	logic                upd_idle_q;
	logic                owner_valid_q;
	logic [CLIENT_W-1:0] owner_client_q;
	logic [RID_W-1:0]    next_id_q;
	logic                idle_q;
	logic                m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	qcmd_t             qcmd;
	qstat_t            qstat;
	entry_t            qload;
	logic              is_owner;
	logic              idle_nx;
	logic [LIM_W-1:0]  held;
	logic [RID_W-1:0]  id_inc;
	logic              full;

	assign pready   = 1'b1;
	assign prdata   = (paddr == REG_MAX_LOCKS_ADDR) ?
		PDATA_W'(max_locks_q) : '0;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign is_owner = owner_valid_q && (owner_client_q == client_q);
	assign held     = LIM_W'(qstat.hit_cnt) + LIM_W'(is_owner) + LIM_W'(1);
	assign full     = (qstat.count == QCNT_W'(QUEUE_DEPTH));
	assign id_inc   = next_id_q + 1'b1;
	assign idle_nx  = idle_q |
		(upd_idle_q && qstat.count == '0 && !owner_valid_q);

	assign qload.client = client_q;
	assign qload.rid    = next_id_q;
	assign qload.dur    = dur_q;

	fla_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qcmd),
		.key    (client_q),
		.load   (qload),
		.stat   (qstat)
	);

	always_comb begin
		qcmd = Q_HOLD;
		case (state_q)
			S_CMP: qcmd = Q_CMP;
			S_EXEC: begin
				case (op_q)
					OP_REQUEST: begin
						if (card_q && held < LIM_W'(max_locks_q) && !full) begin
							qcmd = Q_APPEND;
						end
					end
					OP_GRANT: begin
						if (card_q && qstat.count != '0 && qstat.head_hit
								&& !owner_valid_q) begin
							qcmd = Q_DROP;
						end
					end
					OP_REMOVE: begin
						if (!is_owner && qstat.any_hit) begin
							qcmd = Q_DROP;
						end
					end
					OP_REMOVE_ALL: begin
						if (qstat.any_hit) begin
							qcmd = Q_DROP;
						end
					end
					default: qcmd = Q_HOLD;
				endcase
			end
			default: qcmd = Q_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_locks_q <= MAX_LOCKS_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr == REG_MAX_LOCKS_ADDR) begin
			max_locks_q <= pwdata[MAXL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= '0;
			client_q       <= '0;
			dur_q          <= '0;
			card_q         <= 1'b0;
			status_q       <= ST_OK;
			rid_q          <= '0;
			gdur_q         <= '0;
			upd_idle_q     <= 1'b0;
			owner_valid_q  <= 1'b0;
			owner_client_q <= '0;
			next_id_q      <= RID_W'(1);
			idle_q         <= 1'b1;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q       <= s_tdata[2:0];
						client_q   <= s_tdata[34:3];
						dur_q      <= s_tdata[50:35];
						card_q     <= s_tdata[51];
						status_q   <= ST_OK;
						rid_q      <= '0;
						gdur_q     <= '0;
						upd_idle_q <= 1'b0;
						state_q    <= S_CMP;
					end
				end
				S_CMP: state_q <= S_EXEC;
				S_EXEC: begin
					state_q <= (op_q == OP_REMOVE_ALL && qstat.any_hit) ? S_CMP : S_OUT;
					case (op_q)
						OP_REQUEST: begin
							if (!card_q) begin
								status_q <= ST_CARD_REMOVED;
							end else if (held >= LIM_W'(max_locks_q)) begin
								status_q <= ST_LIMIT;
							end else if (full) begin
								status_q <= ST_QUEUE_FULL;
							end else begin
								rid_q     <= next_id_q;
								next_id_q <= (id_inc == '0) ? RID_W'(1) : id_inc;
								idle_q    <= 1'b0;
							end
						end
						OP_GRANT: begin
							if (!card_q) begin
								status_q <= ST_CARD_REMOVED;
							end else if (qstat.count == '0) begin
								status_q <= ST_NOT_FOUND;
							end else if (qstat.head_hit && !owner_valid_q) begin
								rid_q          <= qstat.head_rid;
								gdur_q         <= qstat.head_dur;
								owner_valid_q  <= 1'b1;
								owner_client_q <= client_q;
							end else begin
								status_q <= ST_PENDING;
							end
						end
						OP_REMOVE: begin
							if (is_owner) begin
								status_q <= ST_ACTIVE_LOCK;
							end else begin
								upd_idle_q <= 1'b1;
								if (!qstat.any_hit) begin
									status_q <= ST_NOT_FOUND;
								end
							end
						end
						OP_REMOVE_ALL: begin
							if (is_owner) begin
								owner_valid_q  <= 1'b0;
								owner_client_q <= '0;
							end
							// one matching entry leaves per pass; compare again
							if (!qstat.any_hit) begin
								upd_idle_q <= 1'b1;
							end
						end
						OP_UNLOCK: begin
							if (is_owner) begin
								owner_valid_q  <= 1'b0;
								owner_client_q <= '0;
								upd_idle_q     <= 1'b1;
							end else begin
								status_q <= ST_NOT_OWNER;
							end
						end
						OP_CHECK: begin
							if (!is_owner) begin
								status_q <= ST_NOT_OWNER;
							end
						end
						default: status_q <= ST_OK;
					endcase
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						idle_q     <= idle_nx;
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, idle_nx,
							(owner_valid_q || qstat.count != '0),
							gdur_q, rid_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the queued lock arbiter: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
	import fla_pkg::*;

	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
	localparam int QUIET_LIMIT = 1000;
	localparam int PHASE_ITEMS = 250;
	localparam int N_PHASES = 8;

	typedef struct packed {
		logic             idle;
		logic             has_req;
		logic [DUR_W-1:0] gdur;
		logic [RID_W-1:0] rid;
		status_t          st;
	} lock_reply_t;

	typedef struct {
		logic [OP_W-1:0]     op;
		logic [CLIENT_W-1:0] cl;
		logic [DUR_W-1:0]    dur;
		logic                card;
		bit                  typed;
		lock_reply_t         want;
	} lock_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	fifo_lock_arbiter_top u_dut (.*);

	always #4 clk = ~clk;

	// shadow copy of the arbiter state
	logic [CLIENT_W-1:0] q_client [QUEUE_DEPTH];
	logic [RID_W-1:0]    q_rid [QUEUE_DEPTH];
	logic [DUR_W-1:0]    q_dur [QUEUE_DEPTH];
	int                  q_len = 0;
	logic                own_v = 1'b0;
	logic [CLIENT_W-1:0] own_client = '0;
	logic [RID_W-1:0]    next_rid = 1;
	logic                idle_f = 1'b1;
	logic [MAXL_W-1:0]   lock_limit = MAX_LOCKS_RESET;

	lock_reply_t lock_replies [$];
	lock_cmd_t   directed [$];
	logic [CLIENT_W-1:0] pool [4];
	bit gaps_on = 1'b1;
	int n_sent = 0;
	int n_checked = 0;
	int n_err = 0;
	int quiet = 0;
	int seen [8] = '{default: 0};

	task automatic drop_slot(input int pos);
		for (int i = pos; i + 1 < q_len; i++) begin
			q_client[i] = q_client[i+1];
			q_rid[i] = q_rid[i+1];
			q_dur[i] = q_dur[i+1];
		end
		if (q_len > 0) q_len--;
	endtask

	task automatic arbitrate(input lock_cmd_t c, output lock_reply_t r);
		int held;
		int i;
		r = '0;
		r.st = ST_OK;
		case (c.op)
			OP_REQUEST: begin
				if (!c.card) begin
					r.st = ST_CARD_REMOVED;
				end else begin
					held = (own_v && own_client == c.cl) ? 1 : 0;
					for (i = 0; i < q_len; i++)
						if (q_client[i] == c.cl) held++;
					if (held + 1 >= lock_limit) begin
						r.st = ST_LIMIT;
					end else if (q_len >= QUEUE_DEPTH) begin
						r.st = ST_QUEUE_FULL;
					end else begin
						q_client[q_len] = c.cl;
						q_rid[q_len] = next_rid;
						q_dur[q_len] = c.dur;
						q_len++;
						r.rid = next_rid;
						next_rid++;
						if (next_rid == 0) next_rid = 1;
						idle_f = 1'b0;
					end
				end
			end
			OP_GRANT: begin
				if (!c.card) begin
					r.st = ST_CARD_REMOVED;
				end else if (q_len == 0) begin
					r.st = ST_NOT_FOUND;
				end else if (q_client[0] == c.cl && !own_v) begin
					r.rid = q_rid[0];
					r.gdur = q_dur[0];
					own_v = 1'b1;
					own_client = c.cl;
					drop_slot(0);
				end else begin
					r.st = ST_PENDING;
				end
			end
			OP_REMOVE: begin
				if (own_v && own_client == c.cl) begin
					r.st = ST_ACTIVE_LOCK;
				end else begin
					r.st = ST_NOT_FOUND;
					for (i = 0; i < q_len; i++) begin
						if (q_client[i] == c.cl) begin
							drop_slot(i);
							r.st = ST_OK;
							break;
						end
					end
					if (q_len == 0 && !own_v) idle_f = 1'b1;
				end
			end
			OP_REMOVE_ALL: begin
				if (own_v && own_client == c.cl) begin
					own_v = 1'b0;
					own_client = '0;
				end
				i = 0;
				while (i < q_len) begin
					if (q_client[i] == c.cl) drop_slot(i);
					else i++;
				end
				if (q_len == 0 && !own_v) idle_f = 1'b1;
			end
			OP_UNLOCK: begin
				if (own_v && own_client == c.cl) begin
					own_v = 1'b0;
					own_client = '0;
					if (q_len == 0) idle_f = 1'b1;
				end else begin
					r.st = ST_NOT_OWNER;
				end
			end
			OP_CHECK: begin
				if (!(own_v && own_client == c.cl)) r.st = ST_NOT_OWNER;
			end
			default: begin
			end
		endcase
		r.has_req = own_v || q_len > 0;
		r.idle = idle_f;
	endtask

	task automatic row(input logic [OP_W-1:0] op, input logic [CLIENT_W-1:0] cl,
			input logic [DUR_W-1:0] dur, input logic card, input bit typed,
			input status_t st = ST_OK, input logic [RID_W-1:0] rid = 0,
			input logic [DUR_W-1:0] gdur = 0, input logic has_req = 0, input logic idle = 0);
		lock_cmd_t c;
		c.op = op;
		c.cl = cl;
		c.dur = dur;
		c.card = card;
		c.typed = typed;
		c.want.st = st;
		c.want.rid = rid;
		c.want.gdur = gdur;
		c.want.has_req = has_req;
		c.want.idle = idle;
		directed.push_back(c);
	endtask

	task automatic issue(input lock_cmd_t c);
		lock_reply_t p;
		while (gaps_on && $urandom_range(99) < 14) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= IN_TDATA_W'({c.card, c.dur, c.cl, c.op});
		s_tvalid <= 1'b1;
		// s_tready is stable between edges; look at it mid-cycle
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		arbitrate(c, p);
		lock_replies.push_back(c.typed ? c.want : p);
		n_sent++;
	endtask

	// mostly clients from a small pool, steered toward the queue head and the owner
	function automatic lock_cmd_t pick_random(input int req_pct);
		lock_cmd_t c;
		int r;
		c.typed = 1'b0;
		c.want = '0;
		c.dur = DUR_W'($urandom_range(16'hFFFF));
		c.card = $urandom_range(99) >= 6;
		c.cl = pool[$urandom_range(3)];
		if ($urandom_range(99) < req_pct) begin
			c.op = OP_REQUEST;
		end else begin
			r = $urandom_range(99);
			if (r < 35) c.op = OP_GRANT;
			else if (r < 50) c.op = OP_REMOVE;
			else if (r < 58) c.op = OP_REMOVE_ALL;
			else if (r < 80) c.op = OP_UNLOCK;
			else if (r < 95) c.op = OP_CHECK;
			else c.op = r[0] ? OP_RSVD_7 : OP_RSVD_6;
		end
		r = $urandom_range(99);
		if (c.op == OP_GRANT && q_len > 0 && r < 60)
			c.cl = q_client[0];
		else if ((c.op == OP_UNLOCK || c.op == OP_CHECK || c.op == OP_REMOVE) && own_v && r < 50)
			c.cl = own_client;
		else if (c.op == OP_REMOVE && q_len > 0 && r < 80)
			c.cl = q_client[$urandom_range(q_len - 1)];
		else if (r >= 95)
			c.cl = $urandom;
		return c;
	endfunction

	task automatic write_lock_limit(input logic [MAXL_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MAX_LOCKS_ADDR;
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		lock_limit = v;
	endtask

	task automatic drain();
		while (lock_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void cmp_field(input string f, input logic [31:0] e, input logic [31:0] a);
		if (e !== a) begin
			$display("%0t: %s expected %0h got %0h", $time, f, e, a);
			n_err++;
		end
	endfunction

	// handshake seen mid-cycle completes at the next rising edge
	always @(negedge clk) begin
		lock_reply_t got;
		lock_reply_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[52:0];
			if (lock_replies.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				n_err++;
			end else begin
				want = lock_replies.pop_front();
				cmp_field("status", want.st, got.st);
				cmp_field("request_id", want.rid, got.rid);
				cmp_field("granted_duration", want.gdur, got.gdur);
				cmp_field("has_requests", want.has_req, got.has_req);
				cmp_field("idle", want.idle, got.idle);
				seen[got.st]++;
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		m_tready <= !gaps_on || $urandom_range(99) >= 14;
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
	end

	initial begin
		while (quiet < QUIET_LIMIT) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [MAXL_W-1:0] phase_limit [N_PHASES];
		phase_limit = '{5'd16, 5'd1, 5'd2, 5'd16, 5'd7, 5'd3, 5'd16, 5'd4};
		phase_limit[5] = MAXL_W'($urandom_range(16, 1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state, card removal, empty queue, grant order, limit at reset value
		row(OP_CHECK, 32'h0, 16'h0, 1'b1, 1, ST_NOT_OWNER, 0, 0, 0, 1);
		row(OP_REQUEST, 32'h0, 16'h0, 1'b0, 1, ST_CARD_REMOVED, 0, 0, 0, 1);
		row(OP_GRANT, 32'h0, 16'h0, 1'b0, 1, ST_CARD_REMOVED, 0, 0, 0, 1);
		row(OP_GRANT, 32'h5, 16'h0, 1'b1, 1, ST_NOT_FOUND, 0, 0, 0, 1);
		row(OP_UNLOCK, 32'h5, 16'h0, 1'b1, 1, ST_NOT_OWNER, 0, 0, 0, 1);
		row(OP_REMOVE, 32'h5, 16'h0, 1'b1, 1, ST_NOT_FOUND, 0, 0, 0, 1);
		row(OP_REMOVE_ALL, 32'h5, 16'h0, 1'b1, 1, ST_OK, 0, 0, 0, 1);
		row(OP_REQUEST, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1, ST_OK, 1, 0, 1, 0);
		row(OP_REQUEST, 32'h0, 16'h0, 1'b1, 1, ST_OK, 2, 0, 1, 0);
		row(OP_GRANT, 32'h0, 16'h0, 1'b1, 1, ST_PENDING, 0, 0, 1, 0);
		row(OP_GRANT, 32'hFFFF_FFFF, 16'h0, 1'b1, 1, ST_OK, 1, 16'hFFFF, 1, 0);
		row(OP_CHECK, 32'hFFFF_FFFF, 16'h0, 1'b1, 1, ST_OK, 0, 0, 1, 0);
		row(OP_REMOVE, 32'hFFFF_FFFF, 16'h0, 1'b1, 1, ST_ACTIVE_LOCK, 0, 0, 1, 0);
		row(OP_GRANT, 32'h0, 16'h0, 1'b1, 1, ST_PENDING, 0, 0, 1, 0);
		row(OP_REQUEST, 32'hFFFF_FFFF, 16'h1, 1'b1, 0);
		row(OP_REQUEST, 32'hFFFF_FFFF, 16'h2, 1'b1, 0);
		row(OP_REQUEST, 32'hFFFF_FFFF, 16'h3, 1'b1, 1, ST_LIMIT, 0, 0, 1, 0);
		row(OP_UNLOCK, 32'hFFFF_FFFF, 16'h0, 1'b0, 0);
		row(OP_REMOVE_ALL, 32'hFFFF_FFFF, 16'h0, 1'b1, 0);
		row(OP_RSVD_6, 32'h0, 16'h0, 1'b1, 0);
		row(OP_RSVD_7, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 0);
		row(OP_GRANT, 32'h0, 16'h0, 1'b1, 0);
		row(OP_UNLOCK, 32'h0, 16'h0, 1'b1, 1, ST_OK, 0, 0, 0, 1);
		foreach (directed[i]) issue(directed[i]);
		s_tvalid <= 1'b0;

		for (int p = 0; p < N_PHASES; p++) begin
			// settle before touching the register, pausing the request stream
			drain();
			write_lock_limit(phase_limit[p]);
			gaps_on = (p != 3);
			pool[0] = $urandom;
			pool[1] = $urandom;
			pool[2] = p[0] ? 32'hFFFF_FFFF : 32'h0;
			pool[3] = $urandom;
			for (int k = 0; k < PHASE_ITEMS; k++)
				issue(pick_random(p[0] ? 35 : 60));
			s_tvalid <= 1'b0;
		end
		gaps_on = 1'b1;

		while (lock_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d lock requests across %0d max_locks settings, %0d results checked, %0d mismatches",
			n_sent, N_PHASES + 1, n_checked, n_err);
		$display("Statuses ok/pend/card/limit/full/notfound/notowner/active: %0d %0d %0d %0d %0d %0d %0d %0d",
			seen[0], seen[1], seen[2], seen[3], seen[4], seen[5], seen[6], seen[7]);
		if (n_err == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
